### src/dcc_spi_pkg.sv
// Shared constants, codes and control types for the DCC packet to SPI encoder.
package dcc_spi_pkg;

    localparam int PREAMBLE_ONES = 16;
    localparam int PRE_W         = $clog2(PREAMBLE_ONES);
    localparam int MAX_BYTES     = 28;
    localparam int BCNT_W        = $clog2(MAX_BYTES);
    localparam int PKT_BYTES     = 5;
    localparam int CACHE_W       = 12;
    localparam int FILL_W        = 4;

    localparam logic [2:0] KIND_SPEED = 3'd0;
    localparam logic [2:0] KIND_F0    = 3'd1;
    localparam logic [2:0] KIND_F5    = 3'd2;
    localparam logic [2:0] KIND_F9    = 3'd3;
    localparam logic [2:0] KIND_F13   = 3'd4;
    localparam logic [2:0] KIND_F21   = 3'd5;

    localparam logic [1:0] PH_PRE   = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_EXTRA = 2'd3;

    typedef struct packed {
        logic       load;
        logic       put_bit;
        logic [1:0] phase;
        logic       emit;
        logic       emit_last;
    } dcc_spi_cmd_t;

    typedef struct packed {
        logic pre_done;
        logic data_done;
        logic cache_full;
        logic fill_nz;
        logic fill_le8;
        logic out_free;
        logic cap;
    } dcc_spi_stat_t;

endpackage

### src/dcc_packet_to_spi_encoder_core.sv
// Top level of the DCC packet to SPI line-code encoder.
// The first output beat is registered once the packer has filled a byte of preamble symbols.
// The packer adds one line bit per cycle while the symbol cache holds under a byte;
// a full cache is emitted as an output beat, which waits while the output is stalled.
// A new item is taken once the previous packet's final beat is in the output register.
// Reset (rst_n, asynchronous) clears the frame counter, the address-form register and control.
module dcc_packet_to_spi_encoder_core
    import dcc_spi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        force_long_address,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    input  logic [13:0] loco_address,
    input  logic [6:0]  speed,
    input  logic        forward,
    input  logic [28:0] function_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  spi_byte,
    output logic        last,
    output logic        loco_done
);

    dcc_spi_cmd_t  cmd;
    dcc_spi_stat_t stat;

    assign cfg_ready = 1'b1;

    dcc_spi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    dcc_spi_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_force_long (force_long_address),
        .restart        (restart),
        .loco_address   (loco_address),
        .speed          (speed),
        .forward        (forward),
        .function_bits  (function_bits),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .spi_byte       (spi_byte),
        .last           (last),
        .loco_done      (loco_done)
    );

endmodule

### src/dcc_spi_ctrl.sv
// Controller state machine that sequences packet load, bit framing and byte output.
module dcc_spi_ctrl
    import dcc_spi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dcc_spi_stat_t stat,
    output dcc_spi_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DATA  = 3'd3;
    localparam logic [2:0] S_EXTRA = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.put_bit   = 1'b0;
        cmd.phase     = PH_PRE;
        cmd.emit      = 1'b0;
        cmd.emit_last = 1'b0;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE, S_START, S_DATA, S_EXTRA:
            begin
                if (stat.cache_full)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = stat.cap;
                        if (stat.cap)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.put_bit = 1'b1;
                    unique case (state_reg)
                        S_PRE:
                        begin
                            cmd.phase = PH_PRE;
                            if (stat.pre_done)
                            begin
                                state_next = S_START;
                            end
                        end
                        S_START:
                        begin
                            cmd.phase  = PH_START;
                            state_next = S_DATA;
                        end
                        S_DATA:
                        begin
                            cmd.phase = PH_DATA;
                            if (stat.data_done)
                            begin
                                state_next = S_EXTRA;
                            end
                        end
                        default:
                        begin
                            cmd.phase  = PH_EXTRA;
                            state_next = S_DRAIN;
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                if (!stat.fill_nz)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = stat.fill_le8 || stat.cap;
                    if (stat.fill_le8 || stat.cap)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/dcc_spi_dp.sv
// Datapath holding the packet bytes, frame counter, symbol cache and output register.
module dcc_spi_dp
    import dcc_spi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_force_long,
    input  logic          restart,
    input  logic [13:0]   loco_address,
    input  logic [6:0]    speed,
    input  logic          forward,
    input  logic [28:0]   function_bits,
    input  dcc_spi_cmd_t  cmd,
    output dcc_spi_stat_t stat,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    spi_byte,
    output logic          last,
    output logic          loco_done
);

    logic                force_long_reg;
    logic [2:0]          frame_reg;
    logic                done_reg;
    logic [7:0]          pkt_reg [PKT_BYTES];
    logic [2:0]          last_idx_reg;
    logic [PRE_W-1:0]    pre_cnt_reg;
    logic [2:0]          byte_idx_reg;
    logic [3:0]          bit_idx_reg;
    logic [CACHE_W-1:0]  cache_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [BCNT_W-1:0]   bcnt_reg;
    logic                out_valid_reg;
    logic [7:0]          spi_byte_reg;
    logic                last_reg;
    logic                loco_done_reg;

    logic [2:0]          kind;
    logic                long_form;
    logic                two_kind;
    logic [7:0]          kb0;
    logic [7:0]          kb1;
    logic [7:0]          a_hi;
    logic [7:0]          a_lo;
    logic [7:0]          a_short;
    logic [7:0]          chk;
    logic [7:0]          pkt_next [PKT_BYTES];
    logic [2:0]          last_idx_next;
    logic                bit_val;
    logic [7:0]          cur_byte;
    logic [3:0]          sym;
    logic [FILL_W-1:0]   sym_len;

    always_comb
    begin
        kind = frame_reg;
        if (restart || (frame_reg > KIND_F21))
        begin
            kind = KIND_SPEED;
        end
    end

    assign long_form = force_long_reg || (|loco_address[13:7]);
    assign a_hi      = {2'b11, loco_address[13:8]};
    assign a_lo      = loco_address[7:0];
    assign a_short   = {1'b0, loco_address[6:0]};

    always_comb
    begin
        two_kind = 1'b0;
        kb0      = 8'h00;
        kb1      = 8'h00;
        case (kind)
            KIND_SPEED:
            begin
                two_kind = 1'b1;
                kb0      = 8'h3F;
                kb1      = {forward, speed};
            end
            KIND_F0:
            begin
                kb0 = {3'b100, function_bits[0], function_bits[4:1]};
            end
            KIND_F5:
            begin
                kb0 = {4'hB, function_bits[8:5]};
            end
            KIND_F9:
            begin
                kb0 = {4'hA, function_bits[12:9]};
            end
            KIND_F13:
            begin
                two_kind = 1'b1;
                kb0      = 8'hDE;
                kb1      = function_bits[20:13];
            end
            default:
            begin
                two_kind = 1'b1;
                kb0      = 8'hDF;
                kb1      = function_bits[28:21];
            end
        endcase
    end

    always_comb
    begin
        chk = kb0 ^ (two_kind ? kb1 : 8'h00) ^ (long_form ? (a_hi ^ a_lo) : a_short);
        for (int i = 0; i < PKT_BYTES; i++)
        begin
            pkt_next[i] = 8'h00;
        end
        if (long_form)
        begin
            pkt_next[0] = a_hi;
            pkt_next[1] = a_lo;
            pkt_next[2] = kb0;
            if (two_kind)
            begin
                pkt_next[3]   = kb1;
                pkt_next[4]   = chk;
                last_idx_next = 3'd4;
            end
            else
            begin
                pkt_next[3]   = chk;
                last_idx_next = 3'd3;
            end
        end
        else
        begin
            pkt_next[0] = a_short;
            pkt_next[1] = kb0;
            if (two_kind)
            begin
                pkt_next[2]   = kb1;
                pkt_next[3]   = chk;
                last_idx_next = 3'd3;
            end
            else
            begin
                pkt_next[2]   = chk;
                last_idx_next = 3'd2;
            end
        end
    end

    assign cur_byte = pkt_reg[byte_idx_reg];

    always_comb
    begin
        case (cmd.phase)
            PH_PRE:   bit_val = 1'b1;
            PH_START: bit_val = 1'b0;
            PH_DATA:
            begin
                if (bit_idx_reg[3])
                begin
                    bit_val = (byte_idx_reg == last_idx_reg);
                end
                else
                begin
                    bit_val = cur_byte[3'd7 - bit_idx_reg[2:0]];
                end
            end
            default:  bit_val = 1'b1;
        endcase
    end

    assign sym     = bit_val ? 4'b0001 : 4'b0011;
    assign sym_len = bit_val ? FILL_W'(2) : FILL_W'(4);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < PKT_BYTES; i++)
            begin
                pkt_reg[i] <= pkt_next[i];
            end
            last_idx_reg <= last_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_long_reg <= 1'b0;
            frame_reg      <= KIND_SPEED;
            done_reg       <= 1'b0;
            pre_cnt_reg    <= '0;
            byte_idx_reg   <= 3'd0;
            bit_idx_reg    <= 4'd0;
            cache_reg      <= '0;
            fill_reg       <= '0;
            bcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                force_long_reg <= cfg_force_long;
            end
            if (cmd.load)
            begin
                frame_reg    <= (kind == KIND_F21) ? KIND_SPEED : kind + 3'd1;
                done_reg     <= (kind == KIND_F21);
                pre_cnt_reg  <= '0;
                byte_idx_reg <= 3'd0;
                bit_idx_reg  <= 4'd0;
                cache_reg    <= '0;
                fill_reg     <= '0;
                bcnt_reg     <= '0;
            end
            else if (cmd.put_bit)
            begin
                cache_reg <= cache_reg | (CACHE_W'(sym) << fill_reg);
                fill_reg  <= fill_reg + sym_len;
                if (cmd.phase == PH_PRE)
                begin
                    pre_cnt_reg <= pre_cnt_reg + PRE_W'(1);
                end
                if (cmd.phase == PH_DATA)
                begin
                    if (bit_idx_reg[3])
                    begin
                        bit_idx_reg  <= 4'd0;
                        byte_idx_reg <= byte_idx_reg + 3'd1;
                    end
                    else
                    begin
                        bit_idx_reg <= bit_idx_reg + 4'd1;
                    end
                end
            end
            else if (cmd.emit)
            begin
                cache_reg <= cache_reg >> 8;
                fill_reg  <= stat.cache_full ? fill_reg - FILL_W'(8) : '0;
                bcnt_reg  <= bcnt_reg + BCNT_W'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            spi_byte_reg  <= cache_reg[7:0];
            last_reg      <= cmd.emit_last;
            loco_done_reg <= done_reg;
        end
    end

    assign stat.pre_done   = (pre_cnt_reg == PRE_W'(PREAMBLE_ONES - 1));
    assign stat.data_done  = bit_idx_reg[3] && (byte_idx_reg == last_idx_reg);
    assign stat.cache_full = (fill_reg >= FILL_W'(8));
    assign stat.fill_nz    = (fill_reg != '0);
    assign stat.fill_le8   = (fill_reg <= FILL_W'(8));
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.cap        = (bcnt_reg == BCNT_W'(MAX_BYTES - 1));

    assign out_valid = out_valid_reg;
    assign spi_byte  = spi_byte_reg;
    assign last      = last_reg;
    assign loco_done = loco_done_reg;

endmodule
